/* hw/rtl/ifd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifd_pkg
// Shared types, register indexes and reset constants of the fall detector.
// ----------------------------------------------------------------------------
package ifd_pkg;

	// default sizes handed to the top level
	localparam int AXIS_BITS_DEF = 16;
	localparam int TIME_BITS_DEF = 32;

	// configuration port sizes
	localparam int IDX_W  = 3;
	localparam int CFG_DW = 32;
	localparam int LVL_W  = 32;
	localparam int HOLD_W = 16;

	// result item packing
	localparam int OUT_FLAGS = 6;
	localparam int OUT_W     = 8;

	// register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_IMPACT_LEVEL  = 3'd0,
		REG_STILL_LEVEL   = 3'd1,
		REG_ROT_LEVEL     = 3'd2,
		REG_IMPACT_HOLD   = 3'd3,
		REG_STILL_HOLD    = 3'd4,
		REG_INACTIVE_WAIT = 3'd5
	} ifd_reg_t;

	// reset values of the registers
	localparam logic [LVL_W-1:0]  IMPACT_LEVEL_RST  = 32'd2835349504;
	localparam logic [LVL_W-1:0]  STILL_LEVEL_RST   = 32'd96628900;
	localparam logic [LVL_W-1:0]  ROT_LEVEL_RST     = 32'd61779600;
	localparam logic [HOLD_W-1:0] IMPACT_HOLD_RST   = 16'd200;
	localparam logic [HOLD_W-1:0] STILL_HOLD_RST    = 16'd2000;
	localparam logic [HOLD_W-1:0] INACTIVE_WAIT_RST = 16'd4000;

	// configuration register file
	typedef struct packed {
		logic [LVL_W-1:0]  impact_level_sq;
		logic [LVL_W-1:0]  still_level_sq;
		logic [LVL_W-1:0]  rotation_level_sq;
		logic [HOLD_W-1:0] impact_hold_ms;
		logic [HOLD_W-1:0] still_hold_ms;
		logic [HOLD_W-1:0] inactive_wait_ms;
	} ifd_cfg_t;

	// magnitude compare results for one item
	typedef struct packed {
		logic above_impact;
		logic below_impact;
		logic still;
		logic low_rotation;
	} ifd_cmp_t;

endpackage

/* hw/rtl/ifd_square_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifd_square_lane
// One axis lane: squares a signed raw axis value into a registered result.
// ----------------------------------------------------------------------------
module ifd_square_lane #(
	parameter int AXIS_BITS = ifd_pkg::AXIS_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic signed [AXIS_BITS-1:0] axis,
	output logic [2*AXIS_BITS-2:0]     sq_s1
);
	import ifd_pkg::*;

	logic signed [2*AXIS_BITS-1:0] prod;

	// square is never negative, top bit of the product is always zero
	assign prod = axis * axis;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1 <= prod[2*AXIS_BITS-2:0];
		end
	end

endmodule

/* hw/rtl/ifd_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifd_merge
// Sums the lane squares into accel and gyro magnitudes and compares them
// with the squared thresholds.
// ----------------------------------------------------------------------------
module ifd_merge #(
	parameter int AXIS_BITS = ifd_pkg::AXIS_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [2*AXIS_BITS-2:0]  acc_sq [3],
	input  logic [2*AXIS_BITS-2:0]  rot_sq [3],
	input  ifd_pkg::ifd_cfg_t       cfg,
	output ifd_pkg::ifd_cmp_t       cmp_s2
);
	import ifd_pkg::*;

	localparam int SQ_W  = 2 * AXIS_BITS - 1;
	localparam int SUM_W = SQ_W + 2;
	localparam int CMP_W = (SUM_W > LVL_W) ? SUM_W : LVL_W;

	logic [SUM_W-1:0] acc_sum;
	logic [SUM_W-1:0] rot_sum;
	logic [CMP_W-1:0] acc_ext;
	logic [CMP_W-1:0] rot_ext;
	ifd_cmp_t         cmp_d;

	// sums of squares
	assign acc_sum = SUM_W'(acc_sq[0]) + SUM_W'(acc_sq[1]) + SUM_W'(acc_sq[2]);
	assign rot_sum = SUM_W'(rot_sq[0]) + SUM_W'(rot_sq[1]) + SUM_W'(rot_sq[2]);
	assign acc_ext = CMP_W'(acc_sum);
	assign rot_ext = CMP_W'(rot_sum);

	// threshold compares
	always_comb begin
		cmp_d.above_impact = acc_ext > CMP_W'(cfg.impact_level_sq);
		cmp_d.below_impact = acc_ext < CMP_W'(cfg.impact_level_sq);
		cmp_d.still        = acc_ext < CMP_W'(cfg.still_level_sq);
		cmp_d.low_rotation = rot_ext < CMP_W'(cfg.rotation_level_sq);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmp_s2 <= cmp_d;
		end
	end

endmodule

/* hw/rtl/ifd_phase.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifd_phase
// Impact, pending and watch phase tracking with the result item register.
// ----------------------------------------------------------------------------
module ifd_phase #(
	parameter int TIME_BITS = ifd_pkg::TIME_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic                        valid_in,
	input  ifd_pkg::ifd_cmp_t           cmp,
	input  logic [TIME_BITS-1:0]        now,
	input  ifd_pkg::ifd_cfg_t           cfg,
	output logic                        out_valid,
	output logic [ifd_pkg::OUT_W-1:0]   out_data
);
	import ifd_pkg::*;

	logic                 impact_q, pending_q, watch_q;
	logic [TIME_BITS-1:0] impact_start_q, still_start_q, watch_start_q;
	logic                 valid_q;
	logic [OUT_W-1:0]     data_q;

	logic                 impact_d, pending_d, watch_d;
	logic [TIME_BITS-1:0] impact_start_d, still_start_d, watch_start_d;
	logic                 ev_impact, ev_potential, ev_confirm;
	logic [TIME_BITS-1:0] el_impact, el_still, el_watch;

	// next phase state for the item in stage two
	always_comb begin
		impact_d       = impact_q;
		pending_d      = pending_q;
		watch_d        = watch_q;
		impact_start_d = impact_start_q;
		still_start_d  = still_start_q;
		watch_start_d  = watch_start_q;
		ev_impact      = 1'b0;
		ev_potential   = 1'b0;
		ev_confirm     = 1'b0;

		// impact phase
		el_impact = now - impact_start_q;
		if (cmp.above_impact) begin
			if (!impact_q) begin
				impact_start_d = now;
				impact_d       = 1'b1;
				ev_impact      = 1'b1;
			end
		end else if (cmp.below_impact && impact_q) begin
			if (el_impact >= TIME_BITS'(cfg.impact_hold_ms)) begin
				impact_d      = 1'b0;
				pending_d     = 1'b1;
				still_start_d = now;
			end
		end

		// stillness after the impact
		el_still = now - still_start_d;
		if (pending_d && cmp.still) begin
			if (el_still >= TIME_BITS'(cfg.still_hold_ms)) begin
				watch_d       = 1'b1;
				watch_start_d = now;
				pending_d     = 1'b0;
				ev_potential  = 1'b1;
			end
		end else begin
			still_start_d = now;
		end

		// post-fall inactivity
		el_watch = now - watch_start_d;
		if (watch_d && cmp.still && cmp.low_rotation) begin
			if (el_watch >= TIME_BITS'(cfg.inactive_wait_ms)) begin
				watch_d    = 1'b0;
				ev_confirm = 1'b1;
			end
		end
	end

	// phase state, committed when the item moves into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			impact_q       <= 1'b0;
			pending_q      <= 1'b0;
			watch_q        <= 1'b0;
			impact_start_q <= '0;
			still_start_q  <= '0;
			watch_start_q  <= '0;
		end else if (load && valid_in) begin
			impact_q       <= impact_d;
			pending_q      <= pending_d;
			watch_q        <= watch_d;
			impact_start_q <= impact_start_d;
			still_start_q  <= still_start_d;
			watch_start_q  <= watch_start_d;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= valid_in;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load && valid_in) begin
			data_q <= {{(OUT_W - OUT_FLAGS){1'b0}}, ev_confirm, ev_potential, ev_impact,
				watch_d, pending_d, impact_d};
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

/* hw/rtl/imu_fall_detector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_fall_detector
// Threshold fall detector over accel and gyro squared magnitudes.
// ----------------------------------------------------------------------------
// pipeline: three register stages from input accept to m_tvalid
//   (square, sum and compare, phase update into the output register)
// throughput: one item per cycle unless m_tready stalls; the phase state
//   closes its loop inside the phase stage; a stall holds full stages
// reset: arst_n clears phase flags, start times and valid bits, and loads
//   the register defaults; cfg writes are always taken
module imu_fall_detector #(
	parameter int AXIS_BITS = ifd_pkg::AXIS_BITS_DEF,
	parameter int TIME_BITS = ifd_pkg::TIME_BITS_DEF,
	localparam int IN_BITS  = 6 * AXIS_BITS + TIME_BITS,
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, time_ms, zero pad
	input  logic [IN_W-1:0]             s_tdata,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// impact_active, fall_pending, post_fall_watch, impact_event,
	// potential_fall_event, fall_confirmed, zero pad
	output logic [ifd_pkg::OUT_W-1:0]   m_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ifd_pkg::IDX_W-1:0]   cfg_index,
	input  logic [ifd_pkg::CFG_DW-1:0]  cfg_data
);
	import ifd_pkg::*;

	localparam int SQ_W = 2 * AXIS_BITS - 1;

	ifd_cfg_t             cfg_q;
	logic                 v_s1, v_s2;
	logic [TIME_BITS-1:0] time_s1, time_s2;
	logic                 adv1, adv2, adv3;
	logic [SQ_W-1:0]      acc_sq [3];
	logic [SQ_W-1:0]      rot_sq [3];
	ifd_cmp_t             cmp_s2;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.impact_level_sq   <= IMPACT_LEVEL_RST;
			cfg_q.still_level_sq    <= STILL_LEVEL_RST;
			cfg_q.rotation_level_sq <= ROT_LEVEL_RST;
			cfg_q.impact_hold_ms    <= IMPACT_HOLD_RST;
			cfg_q.still_hold_ms     <= STILL_HOLD_RST;
			cfg_q.inactive_wait_ms  <= INACTIVE_WAIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IMPACT_LEVEL:  cfg_q.impact_level_sq   <= cfg_data[LVL_W-1:0];
				REG_STILL_LEVEL:   cfg_q.still_level_sq    <= cfg_data[LVL_W-1:0];
				REG_ROT_LEVEL:     cfg_q.rotation_level_sq <= cfg_data[LVL_W-1:0];
				REG_IMPACT_HOLD:   cfg_q.impact_hold_ms    <= cfg_data[HOLD_W-1:0];
				REG_STILL_HOLD:    cfg_q.still_hold_ms     <= cfg_data[HOLD_W-1:0];
				REG_INACTIVE_WAIT: cfg_q.inactive_wait_ms  <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// per-stage advance, a stage moves when empty or when the next one moves
	assign adv3     = !m_tvalid || m_tready;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign s_tready = adv1;

	// valid bits of the first two stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= s_tvalid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// timestamp alongside the magnitudes
	always_ff @(posedge clk) begin
		if (adv1) begin
			time_s1 <= s_tdata[6*AXIS_BITS +: TIME_BITS];
		end
		if (adv2) begin
			time_s2 <= time_s1;
		end
	end

	// six squaring lanes, accel first then gyro
	for (genvar i = 0; i < 3; i++) begin : g_lane
		ifd_square_lane #(.AXIS_BITS(AXIS_BITS)) u_acc_lane (
			.clk   (clk),
			.en    (adv1),
			.axis  (s_tdata[i*AXIS_BITS +: AXIS_BITS]),
			.sq_s1 (acc_sq[i])
		);
		ifd_square_lane #(.AXIS_BITS(AXIS_BITS)) u_rot_lane (
			.clk   (clk),
			.en    (adv1),
			.axis  (s_tdata[(i+3)*AXIS_BITS +: AXIS_BITS]),
			.sq_s1 (rot_sq[i])
		);
	end

	// magnitude sums and threshold compares
	ifd_merge #(.AXIS_BITS(AXIS_BITS)) u_merge (
		.clk    (clk),
		.en     (adv2),
		.acc_sq (acc_sq),
		.rot_sq (rot_sq),
		.cfg    (cfg_q),
		.cmp_s2 (cmp_s2)
	);

	// phase tracking and result register
	ifd_phase #(.TIME_BITS(TIME_BITS)) u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv3),
		.valid_in  (v_s2),
		.cmp       (cmp_s2),
		.now       (time_s2),
		.cfg       (cfg_q),
		.out_valid (m_tvalid),
		.out_data  (m_tdata)
	);

endmodule

/* hw/rtl/imu_fall_detector_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_fall_detector_checker
// Port-level checks of the fall detector result items, bound to the top.
// ----------------------------------------------------------------------------
module imu_fall_detector_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [ifd_pkg::OUT_W-1:0] m_tdata,
	input  logic                      m_tvalid,
	input  logic                      m_tready
);
	import ifd_pkg::*;

	// a stalled result item holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");

	// an impact event leaves the impact phase active
	a_impact_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> m_tdata[0])
		else $error("impact event without impact phase");

	// a potential fall ends the pending phase and opens the watch unless confirmed
	a_potential: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> !m_tdata[1] && (m_tdata[2] || m_tdata[5]))
		else $error("potential fall event with inconsistent phase flags");

	// a confirmed fall closes the watch
	a_confirm: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[5] |-> !m_tdata[2])
		else $error("fall confirmed while watch still open");

endmodule

bind imu_fall_detector imu_fall_detector_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tdata  (m_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);
